[design/tpm_pkg.sv]
// ----------------------------------------------------------------------------
// tpm_pkg
// Shared types and constants of the tile to pixel mapper.
// ----------------------------------------------------------------------------
package tpm_pkg;

  localparam int unsigned TILE_W    = 16;
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned SEL_W     = 2;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned DIV_CNT_W = 4;
  localparam int unsigned MUL_CNT_W = 3;

  // number of products formed per convert
  localparam logic [MUL_CNT_W-1:0] MUL_STEPS = 3'd4;

  localparam logic REG_COL_COUNT = 1'b0;
  localparam logic REG_ROW_COUNT = 1'b1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_CONV = 1'b1;

  localparam logic [SEL_W-1:0] SEL_COL_X = 2'd0;
  localparam logic [SEL_W-1:0] SEL_COL_Y = 2'd1;
  localparam logic [SEL_W-1:0] SEL_ROW_X = 2'd2;
  localparam logic [SEL_W-1:0] SEL_ROW_Y = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_MUL
  } tpm_state_e;

endpackage

[design/tile_to_pixel_mapper_core.sv]
// ----------------------------------------------------------------------------
// tile_to_pixel_mapper_core
// Maps tile coordinates to pixel coordinates under a periodic tiling held in
// per-column and per-row step tables.
// ----------------------------------------------------------------------------
// channel   direction  handshake                      payload
// command   in         start_i & !busy_o              kind, table_sel, entry_index,
//                                                     entry_value, tile_x, tile_y
// result    out        result_valid_o, one cycle      pixel_x, pixel_y
// config    in         psel & penable & pwrite        col_count, row_count
//
// a load gives no result
// a convert runs a 16 step radix-2 divider, then one step table read per
// entry from the column and row memories, then four products through one
// shared 16x32 multiplier
// tables read as zero after reset through per-entry valid bits; no clearing pass
// results cannot be stalled and are shown for exactly one cycle
// ----------------------------------------------------------------------------
module tile_to_pixel_mapper_core
  import tpm_pkg::*;
#(
  parameter int unsigned MAX_COLS = 16,
  parameter int unsigned MAX_ROWS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     kind_i,
  input  logic [SEL_W-1:0]         table_sel_i,
  input  logic [IDX_W-1:0]         entry_index_i,
  input  logic signed [STEP_W-1:0] entry_value_i,
  input  logic [TILE_W-1:0]        tile_x_i,
  input  logic [TILE_W-1:0]        tile_y_i,

  output logic                     result_valid_o,
  output logic signed [PIX_W-1:0]  pixel_x_o,
  output logic signed [PIX_W-1:0]  pixel_y_o,

  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int unsigned MAXN = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int unsigned CAW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RAW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CCW  = $clog2(MAX_COLS + 1);
  localparam int unsigned RCW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned WW   = $clog2(MAXN + 1);
  localparam int unsigned SUMW = STEP_W + WW;

  // configuration registers
  logic [CNT_W-1:0] col_cnt_q, row_cnt_q;
  logic             cfg_wr;

  // step memories: x step in the low half, y step in the high half
  logic [2*STEP_W-1:0] col_mem [MAX_COLS];
  logic [2*STEP_W-1:0] row_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] vld_cx_q, vld_cy_q;
  logic [MAX_ROWS-1:0] vld_rx_q, vld_ry_q;
  logic [2*STEP_W-1:0] col_rd_q, row_rd_q;
  logic                rd_cx_vld_q, rd_cy_vld_q, rd_rx_vld_q, rd_ry_vld_q;
  logic [CAW-1:0]      col_ra, col_wa;
  logic [RAW-1:0]      row_ra, row_wa;
  logic                col_idx_ok, row_idx_ok;
  logic                ld_col_x, ld_col_y, ld_row_x, ld_row_y;

  tpm_state_e state_q, state_d;
  logic       accept, conv_accept, load_accept;

  logic [CCW-1:0]       cc_q, cc_d, rem_c_q, rem_c_d;
  logic [RCW-1:0]       rc_q, rc_d, rem_r_q, rem_r_d;
  logic [TILE_W-1:0]    quo_c_q, quo_c_d, quo_r_q, quo_r_d;
  logic [CCW:0]         div_tc;
  logic [RCW:0]         div_tr;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  logic [WW-1:0]        walk_k_q, walk_k_d, wmax_q, wmax_d, walk_p;
  logic [STEP_W-1:0]    cx, cy, rx, ry;
  logic [SUMW-1:0]      tot_cx_q, tot_cx_d, tot_cy_q, tot_cy_d;
  logic [SUMW-1:0]      tot_rx_q, tot_rx_d, tot_ry_q, tot_ry_d;
  logic [PIX_W-1:0]     acc_x_q, acc_x_d, acc_y_q, acc_y_d;

  logic [MUL_CNT_W-1:0] mul_k_q, mul_k_d;
  logic [TILE_W-1:0]    mul_a;
  logic [SUMW-1:0]      mul_b_n;
  logic [PIX_W-1:0]     mul_b, prod_q, prod_d;

  logic                 res_vld_q, res_vld_d;
  logic [PIX_W-1:0]     pix_x_q, pix_x_d, pix_y_q, pix_y_d;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= CNT_W'(1);
      row_cnt_q <= CNT_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_COL_COUNT) begin
        col_cnt_q <= pwdata[CNT_W-1:0];
      end else begin
        row_cnt_q <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_COL_COUNT) begin
      prdata[CNT_W-1:0] = col_cnt_q;
    end else begin
      prdata[CNT_W-1:0] = row_cnt_q;
    end
  end

  // --------------------------------------------------------------------------
  // command transfer and table loads
  // --------------------------------------------------------------------------
  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign conv_accept = accept && (kind_i == KIND_CONV);
  assign load_accept = accept && (kind_i == KIND_LOAD);

  assign col_wa     = CAW'(entry_index_i);
  assign row_wa     = RAW'(entry_index_i);
  assign col_idx_ok = (32'(entry_index_i) < MAX_COLS);
  assign row_idx_ok = (32'(entry_index_i) < MAX_ROWS);
  assign ld_col_x   = load_accept && col_idx_ok && (table_sel_i == SEL_COL_X);
  assign ld_col_y   = load_accept && col_idx_ok && (table_sel_i == SEL_COL_Y);
  assign ld_row_x   = load_accept && row_idx_ok && (table_sel_i == SEL_ROW_X);
  assign ld_row_y   = load_accept && row_idx_ok && (table_sel_i == SEL_ROW_Y);

  assign col_ra = walk_k_q[CAW-1:0];
  assign row_ra = walk_k_q[RAW-1:0];

  always_ff @(posedge clk_i) begin
    if (ld_col_x) begin
      col_mem[col_wa][STEP_W-1:0] <= entry_value_i;
    end
    if (ld_col_y) begin
      col_mem[col_wa][2*STEP_W-1:STEP_W] <= entry_value_i;
    end
    if (ld_row_x) begin
      row_mem[row_wa][STEP_W-1:0] <= entry_value_i;
    end
    if (ld_row_y) begin
      row_mem[row_wa][2*STEP_W-1:STEP_W] <= entry_value_i;
    end
    if (state_q == ST_WALK) begin
      col_rd_q <= col_mem[col_ra];
      row_rd_q <= row_mem[row_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_cx_q    <= '0;
      vld_cy_q    <= '0;
      vld_rx_q    <= '0;
      vld_ry_q    <= '0;
      rd_cx_vld_q <= 1'b0;
      rd_cy_vld_q <= 1'b0;
      rd_rx_vld_q <= 1'b0;
      rd_ry_vld_q <= 1'b0;
    end else begin
      if (ld_col_x) begin
        vld_cx_q[col_wa] <= 1'b1;
      end
      if (ld_col_y) begin
        vld_cy_q[col_wa] <= 1'b1;
      end
      if (ld_row_x) begin
        vld_rx_q[row_wa] <= 1'b1;
      end
      if (ld_row_y) begin
        vld_ry_q[row_wa] <= 1'b1;
      end
      if (state_q == ST_WALK) begin
        rd_cx_vld_q <= vld_cx_q[col_ra];
        rd_cy_vld_q <= vld_cy_q[col_ra];
        rd_rx_vld_q <= vld_rx_q[row_ra];
        rd_ry_vld_q <= vld_ry_q[row_ra];
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath helpers
  // --------------------------------------------------------------------------
  assign div_tc = {rem_c_q, quo_c_q[TILE_W-1]};
  assign div_tr = {rem_r_q, quo_r_q[TILE_W-1]};

  assign walk_p = walk_k_q - WW'(1);
  assign cx = rd_cx_vld_q ? col_rd_q[STEP_W-1:0]        : '0;
  assign cy = rd_cy_vld_q ? col_rd_q[2*STEP_W-1:STEP_W] : '0;
  assign rx = rd_rx_vld_q ? row_rd_q[STEP_W-1:0]        : '0;
  assign ry = rd_ry_vld_q ? row_rd_q[2*STEP_W-1:STEP_W] : '0;

  always_comb begin
    mul_a = mul_k_q[1] ? quo_r_q : quo_c_q;
    case (mul_k_q[1:0])
      2'd0:    mul_b_n = tot_cx_q;
      2'd1:    mul_b_n = tot_cy_q;
      2'd2:    mul_b_n = tot_rx_q;
      default: mul_b_n = tot_ry_q;
    endcase
    mul_b = {{(PIX_W-SUMW){mul_b_n[SUMW-1]}}, mul_b_n};
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      div_cnt_q <= '0;
      walk_k_q  <= '0;
      mul_k_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
      walk_k_q  <= walk_k_d;
      mul_k_q   <= mul_k_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cc_q     <= cc_d;
    rc_q     <= rc_d;
    rem_c_q  <= rem_c_d;
    rem_r_q  <= rem_r_d;
    quo_c_q  <= quo_c_d;
    quo_r_q  <= quo_r_d;
    wmax_q   <= wmax_d;
    tot_cx_q <= tot_cx_d;
    tot_cy_q <= tot_cy_d;
    tot_rx_q <= tot_rx_d;
    tot_ry_q <= tot_ry_d;
    acc_x_q  <= acc_x_d;
    acc_y_q  <= acc_y_d;
    prod_q   <= prod_d;
    pix_x_q  <= pix_x_d;
    pix_y_q  <= pix_y_d;
  end

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    walk_k_d  = walk_k_q;
    mul_k_d   = mul_k_q;
    res_vld_d = 1'b0;
    cc_d      = cc_q;
    rc_d      = rc_q;
    rem_c_d   = rem_c_q;
    rem_r_d   = rem_r_q;
    quo_c_d   = quo_c_q;
    quo_r_d   = quo_r_q;
    wmax_d    = wmax_q;
    tot_cx_d  = tot_cx_q;
    tot_cy_d  = tot_cy_q;
    tot_rx_d  = tot_rx_q;
    tot_ry_d  = tot_ry_q;
    acc_x_d   = acc_x_q;
    acc_y_d   = acc_y_q;
    prod_d    = prod_q;
    pix_x_d   = pix_x_q;
    pix_y_d   = pix_y_q;

    case (state_q)
      ST_IDLE: begin
        if (conv_accept) begin
          // zero counts act as one, large counts clamp to the table depth
          if (col_cnt_q == '0) begin
            cc_d = CCW'(1);
          end else if (32'(col_cnt_q) > MAX_COLS) begin
            cc_d = CCW'(MAX_COLS);
          end else begin
            cc_d = CCW'(col_cnt_q);
          end
          if (row_cnt_q == '0) begin
            rc_d = RCW'(1);
          end else if (32'(row_cnt_q) > MAX_ROWS) begin
            rc_d = RCW'(MAX_ROWS);
          end else begin
            rc_d = RCW'(row_cnt_q);
          end
          quo_c_d   = tile_x_i;
          quo_r_d   = tile_y_i;
          rem_c_d   = '0;
          rem_r_d   = '0;
          div_cnt_d = '0;
          state_d   = ST_DIV;
        end
      end

      ST_DIV: begin
        // restoring divide, one quotient bit per cycle on each axis
        if (div_tc >= {1'b0, cc_q}) begin
          rem_c_d = CCW'(div_tc - {1'b0, cc_q});
          quo_c_d = {quo_c_q[TILE_W-2:0], 1'b1};
        end else begin
          rem_c_d = div_tc[CCW-1:0];
          quo_c_d = {quo_c_q[TILE_W-2:0], 1'b0};
        end
        if (div_tr >= {1'b0, rc_q}) begin
          rem_r_d = RCW'(div_tr - {1'b0, rc_q});
          quo_r_d = {quo_r_q[TILE_W-2:0], 1'b1};
        end else begin
          rem_r_d = div_tr[RCW-1:0];
          quo_r_d = {quo_r_q[TILE_W-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
        if (div_cnt_q == '1) begin
          wmax_d   = (WW'(cc_q) > WW'(rc_q)) ? WW'(cc_q) : WW'(rc_q);
          walk_k_d = '0;
          tot_cx_d = '0;
          tot_cy_d = '0;
          tot_rx_d = '0;
          tot_ry_d = '0;
          acc_x_d  = '0;
          acc_y_d  = '0;
          state_d  = ST_WALK;
        end
      end

      ST_WALK: begin
        // read issued for entry walk_k, data of entry walk_k - 1 arrives
        if (walk_k_q != '0) begin
          if (walk_p < WW'(cc_q)) begin
            tot_cx_d = tot_cx_q + {{(SUMW-STEP_W){cx[STEP_W-1]}}, cx};
            tot_cy_d = tot_cy_q + {{(SUMW-STEP_W){cy[STEP_W-1]}}, cy};
          end
          if (walk_p < WW'(rc_q)) begin
            tot_rx_d = tot_rx_q + {{(SUMW-STEP_W){rx[STEP_W-1]}}, rx};
            tot_ry_d = tot_ry_q + {{(SUMW-STEP_W){ry[STEP_W-1]}}, ry};
          end
          if (walk_p < WW'(rem_c_q) && walk_p < WW'(rem_r_q)) begin
            acc_x_d = acc_x_q + {{(PIX_W-STEP_W){cx[STEP_W-1]}}, cx}
                              + {{(PIX_W-STEP_W){rx[STEP_W-1]}}, rx};
            acc_y_d = acc_y_q + {{(PIX_W-STEP_W){cy[STEP_W-1]}}, cy}
                              + {{(PIX_W-STEP_W){ry[STEP_W-1]}}, ry};
          end else if (walk_p < WW'(rem_c_q)) begin
            acc_x_d = acc_x_q + {{(PIX_W-STEP_W){cx[STEP_W-1]}}, cx};
            acc_y_d = acc_y_q + {{(PIX_W-STEP_W){cy[STEP_W-1]}}, cy};
          end else if (walk_p < WW'(rem_r_q)) begin
            acc_x_d = acc_x_q + {{(PIX_W-STEP_W){rx[STEP_W-1]}}, rx};
            acc_y_d = acc_y_q + {{(PIX_W-STEP_W){ry[STEP_W-1]}}, ry};
          end
        end
        if (walk_k_q == wmax_q) begin
          mul_k_d = '0;
          state_d = ST_MUL;
        end else begin
          walk_k_d = walk_k_q + WW'(1);
        end
      end

      ST_MUL: begin
        // product k is formed in step k and added in step k + 1
        if (mul_k_q != MUL_STEPS) begin
          prod_d = PIX_W'({{(PIX_W-TILE_W){1'b0}}, mul_a} * mul_b);
        end
        if (mul_k_q != '0) begin
          if (mul_k_q[0]) begin
            acc_x_d = acc_x_q + prod_q;
          end else begin
            acc_y_d = acc_y_q + prod_q;
          end
        end
        mul_k_d = mul_k_q + MUL_CNT_W'(1);
        if (mul_k_q == MUL_STEPS) begin
          pix_x_d   = acc_x_q;
          pix_y_d   = acc_y_q + prod_q;
          res_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign result_valid_o = res_vld_q;
  assign pixel_x_o      = pix_x_q;
  assign pixel_y_o      = pix_y_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_result_after_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == ST_MUL) && !busy_o)
    else $error("result strobe without finished product phase");

  a_conv_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (conv_accept) |=> busy_o && (state_q == ST_DIV))
    else $error("convert transfer did not start the divider");

  a_load_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_accept) |=> !busy_o && !result_valid_o)
    else $error("load transfer produced a result or stayed busy");

  a_walk_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (walk_k_q <= wmax_q))
    else $error("table walk ran past the period length");

endmodule
